[rtl/sorted_adjacency_list_builder_unit_defines.svh]
// assertion macros for the sorted adjacency list builder
`ifndef SORTED_ADJACENCY_LIST_BUILDER_UNIT_DEFINES_SVH
`define SORTED_ADJACENCY_LIST_BUILDER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define SALB_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define SALB_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define SALB_ASSERT_IMP(label, clk, rst_n, a, c)
`define SALB_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

[rtl/salb_pkg.sv]
// shared constants and types of the sorted adjacency list builder
package salb_pkg;
    localparam int MAX_VERTICES = 32;
    localparam int MAX_DEGREE = 32;
    localparam int VW = 5;
    localparam int LW = $clog2(MAX_DEGREE + 1);
    localparam int RW = $clog2(MAX_VERTICES);

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_LIST = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // control from the sequencer to the cell row
    typedef struct packed {
        logic          load;
        logic          insert;
        logic [LW-1:0] len;
        logic [VW-1:0] tgt;
        logic          shift;
    } cell_ctl_t;
endpackage

[rtl/salb_cell.sv]
// one cell of the row: holds one entry, shifts toward the head, inserts in place
module salb_cell (
    input  logic                 clk,
    input  salb_pkg::cell_ctl_t  ctl,
    input  logic [4:0]           load_val,
    input  logic [4:0]           prev_val,
    input  logic                 prev_gt,
    input  logic [4:0]           next_val,
    input  logic [salb_pkg::LW-1:0] idx,
    output logic [4:0]           val,
    output logic                 gt
);
    import salb_pkg::*;
    logic [4:0] val_reg;
    logic [4:0] val_next;

    // entry is greater than the new target and sits inside the row
    assign gt = (idx < ctl.len) && (val_reg > ctl.tgt);
    assign val = val_reg;

    // next value of the entry
    always_comb
    begin
        val_next = val_reg;
        if (ctl.load)
            val_next = load_val;
        else if (ctl.insert)
        begin
            if (idx <= ctl.len)
            begin
                if (prev_gt)
                    val_next = prev_val;
                else if (gt || idx == ctl.len)
                    val_next = ctl.tgt;
            end
        end
        else if (ctl.shift)
            val_next = next_val;
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end
endmodule

[rtl/salb_row.sv]
// chain of cells holding the working row
module salb_row (
    input  logic                clk,
    input  salb_pkg::cell_ctl_t ctl,
    input  logic [salb_pkg::MAX_DEGREE*5-1:0] load_word,
    output logic [salb_pkg::MAX_DEGREE*5-1:0] row_word
);
    import salb_pkg::*;
    logic [4:0] v [MAX_DEGREE];
    logic       g [MAX_DEGREE];

    for (genvar i = 0; i < MAX_DEGREE; i++)
    begin : g_cell
        logic [4:0] pv;
        logic       pg;
        logic [4:0] nv;
        if (i == 0)
        begin : g_head
            assign pv = 5'd0;
            assign pg = 1'b0;
        end
        else
        begin : g_mid
            assign pv = v[i-1];
            assign pg = g[i-1];
        end
        if (i == MAX_DEGREE - 1)
        begin : g_tail
            assign nv = 5'd0;
        end
        else
        begin : g_body
            assign nv = v[i+1];
        end
        salb_cell u_cell (
            .clk      (clk),
            .ctl      (ctl),
            .load_val (load_word[i*5 +: 5]),
            .prev_val (pv),
            .prev_gt  (pg),
            .next_val (nv),
            .idx      (LW'(i)),
            .val      (v[i]),
            .gt       (g[i])
        );
        assign row_word[i*5 +: 5] = v[i];
    end
endmodule

[rtl/sorted_adjacency_list_builder_unit.sv]
// top level: row memory, length table, sequencer and output register
// Each vertex row is one memory word that is loaded into a chain of cells.
// An insert passes through acceptance, memory read, load into the cells,
// a step in which every cell compares with the target and shifts in
// parallel, and write back; its beat is presented during write back. A list
// goes through acceptance, memory read and load, then gives one beat per
// successor as the cells shift toward the head, held while a beat waits
// untaken; a rejected insert or list, an empty list, a clear and an ignored
// mode give one beat the cycle after acceptance. A beat waiting in the
// result register holds off the next item until it is taken.
// Out-of-range checks use min(vertex_count, 32).
`include "sorted_adjacency_list_builder_unit_defines.svh"
module sorted_adjacency_list_builder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // mode[1:0], source_vertex[6:2], target_vertex[11:7]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // status[1:0], successor[6:2]
    output logic        m_axis_tuser,   // has_neighbor
    output logic        m_axis_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data        // vertex_count
);
    import salb_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_LOAD = 3'd2;
    localparam logic [2:0] S_INS = 3'd3;
    localparam logic [2:0] S_WB = 3'd4;
    localparam logic [2:0] S_LIST = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic [5:0]  vcount_reg;
    logic [LW-1:0] len_reg [MAX_VERTICES];
    logic [RW-1:0] src_reg;
    logic [VW-1:0] tgt_reg;
    logic [LW-1:0] cnt_reg;
    logic [MAX_DEGREE*5-1:0] mem [MAX_VERTICES];
    logic [MAX_DEGREE*5-1:0] rd_reg;
    logic [MAX_DEGREE*5-1:0] row_word;
    cell_ctl_t   ctl;
    logic        ov_reg;
    logic [1:0]  ost_reg;
    logic        ohn_reg;
    logic [4:0]  osucc_reg;
    logic        olast_reg;
    logic        out_free;
    logic        in_acc;
    logic [1:0]  in_mode;
    logic [4:0]  in_src, in_tgt;
    logic [6:0]  lim;
    logic        beat1;
    logic [1:0]  beat1_st;

    assign in_mode = s_axis_tdata[1:0];
    assign in_src = s_axis_tdata[6:2];
    assign in_tgt = s_axis_tdata[11:7];
    assign lim = (vcount_reg > 6'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : {1'b0, vcount_reg};
    assign out_free = !ov_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && out_free;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign cfg_ready = 1'b1;

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = {1'b0, osucc_reg, ost_reg};
    assign m_axis_tuser = ohn_reg;
    assign m_axis_tlast = olast_reg;

    // row store: one word per vertex
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
            rd_reg <= mem[src_reg];
        if (state_reg == S_WB)
            mem[src_reg] <= row_word;
    end

    // cell control
    always_comb
    begin
        ctl.load = (state_reg == S_LOAD);
        ctl.insert = (state_reg == S_INS);
        ctl.len = cnt_reg;
        ctl.tgt = tgt_reg;
        ctl.shift = (state_reg == S_LIST) && out_free;
    end

    salb_row u_row (
        .clk       (clk),
        .ctl       (ctl),
        .load_word (rd_reg),
        .row_word  (row_word)
    );

    // decide single-beat replies on acceptance
    always_comb
    begin
        beat1 = 1'b1;
        beat1_st = ST_OK;
        unique case (in_mode)
            MODE_INSERT:
            begin
                if ({2'b0, in_src} >= lim || {2'b0, in_tgt} >= lim)
                    beat1_st = ST_RANGE;
                else if (len_reg[in_src[RW-1:0]] >= LW'(MAX_DEGREE))
                    beat1_st = ST_FULL;
                else
                    beat1 = 1'b0;
            end
            MODE_LIST:
            begin
                if ({2'b0, in_src} >= lim)
                    beat1_st = ST_RANGE;
                else if (len_reg[in_src[RW-1:0]] != '0)
                    beat1 = 1'b0;
            end
            default:
            begin
                beat1 = 1'b1;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_acc && !beat1) state_next = S_READ;
            S_READ:  state_next = S_LOAD;
            S_LOAD:  state_next = ohn_reg ? S_LIST : S_INS;
            S_INS:   state_next = S_WB;
            S_WB:    state_next = S_IDLE;
            S_LIST:  if (out_free && cnt_reg == LW'(1)) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            vcount_reg <= 6'd32;
            ov_reg <= 1'b0;
            for (int i = 0; i < MAX_VERTICES; i++)
                len_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                vcount_reg <= cfg_data;
            if ((in_acc && beat1) || state_reg == S_INS || ctl.shift)
                ov_reg <= 1'b1;
            else if (m_axis_tready)
                ov_reg <= 1'b0;
            if (in_acc && in_mode == MODE_CLEAR)
                for (int i = 0; i < MAX_VERTICES; i++)
                    len_reg[i] <= '0;
            if (state_reg == S_INS)
                len_reg[src_reg] <= cnt_reg + LW'(1);
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            src_reg <= in_src[RW-1:0];
            tgt_reg <= in_tgt;
            cnt_reg <= len_reg[in_src[RW-1:0]];
            // ohn_reg doubles as list flag until the first beat
            ohn_reg <= (in_mode == MODE_LIST) && !beat1;
            ost_reg <= beat1_st;
            osucc_reg <= '0;
            olast_reg <= 1'b1;
        end
        if (state_reg == S_INS)
        begin
            ohn_reg <= 1'b0;
            ost_reg <= ST_OK;
            osucc_reg <= '0;
            olast_reg <= 1'b1;
        end
        if (ctl.shift)
        begin
            ohn_reg <= 1'b1;
            ost_reg <= ST_OK;
            osucc_reg <= row_word[4:0];
            olast_reg <= (cnt_reg == LW'(1));
            cnt_reg <= cnt_reg - LW'(1);
        end
    end

    `SALB_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, !s_axis_tready)
    `SALB_ASSERT_NXT(a_ins_beat, clk, rst_n, state_reg == S_INS, m_axis_tvalid && m_axis_tlast)
    `SALB_ASSERT_IMP(a_list_nonzero, clk, rst_n, state_reg == S_LIST, cnt_reg != '0)
endmodule

[sim/tb_sorted_adjacency_list_builder_unit.sv]
// self-checking testbench for the sorted adjacency list builder
module tb_sorted_adjacency_list_builder_unit;
    import salb_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [1:0] status;
        logic       has_neighbor;
        logic [4:0] successor;
        logic       last;
    } succ_beat_t;

    // mirror of the graph rows and the queue of beats they should produce
    class adjacency_rows_mirror;
        logic [4:0] rows [MAX_VERTICES][MAX_DEGREE];
        int         row_len [MAX_VERTICES];
        logic [5:0] vertex_count;
        succ_beat_t pending_beats [$];
        int         mismatches;

        function new();
            foreach (row_len[v]) row_len[v] = 0;
            vertex_count = 6'd32;
            mismatches = 0;
        endfunction

        function int vertex_limit();
            return (vertex_count > MAX_VERTICES) ? MAX_VERTICES : int'(vertex_count);
        endfunction

        function void push_beat(logic [1:0] st, logic hn, logic [4:0] succ, logic lst);
            succ_beat_t b;
            b.status = st;
            b.has_neighbor = hn;
            b.successor = succ;
            b.last = lst;
            pending_beats.push_back(b);
        endfunction

        // work out the beats caused by one accepted request
        function void note_request(logic [1:0] mode, logic [4:0] src, logic [4:0] tgt);
            int lim;
            int pos;
            lim = vertex_limit();
            case (mode)
                MODE_INSERT:
                begin
                    if (src >= lim || tgt >= lim)
                        push_beat(ST_RANGE, 1'b0, 5'd0, 1'b1);
                    else if (row_len[src] >= MAX_DEGREE)
                        push_beat(ST_FULL, 1'b0, 5'd0, 1'b1);
                    else
                    begin
                        // new copy goes after equal entries
                        pos = row_len[src];
                        while (pos > 0 && rows[src][pos-1] > tgt)
                        begin
                            rows[src][pos] = rows[src][pos-1];
                            pos--;
                        end
                        rows[src][pos] = tgt;
                        row_len[src]++;
                        push_beat(ST_OK, 1'b0, 5'd0, 1'b1);
                    end
                end
                MODE_LIST:
                begin
                    if (src >= lim)
                        push_beat(ST_RANGE, 1'b0, 5'd0, 1'b1);
                    else if (row_len[src] == 0)
                        push_beat(ST_OK, 1'b0, 5'd0, 1'b1);
                    else
                        for (int i = 0; i < row_len[src]; i++)
                            push_beat(ST_OK, 1'b1, rows[src][i], i + 1 == row_len[src]);
                end
                MODE_CLEAR:
                begin
                    foreach (row_len[v]) row_len[v] = 0;
                    push_beat(ST_OK, 1'b0, 5'd0, 1'b1);
                end
                default:
                    push_beat(ST_OK, 1'b0, 5'd0, 1'b1);
            endcase
        endfunction

        // compare one output beat with the oldest pending one
        function void check_beat(succ_beat_t got);
            succ_beat_t want;
            if (pending_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: status %0d hn %0d succ %0d last %0d",
                             got.status, got.has_neighbor, got.successor, got.last);
                return;
            end
            want = pending_beats.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"beat mismatch: exp st %0d hn %0d succ %0d last %0d, ",
                              "got st %0d hn %0d succ %0d last %0d"},
                             want.status, want.has_neighbor, want.successor, want.last,
                             got.status, got.has_neighbor, got.successor, got.last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [5:0]  cfg_data;

    int sender_idle_pct;
    int receiver_stall_pct;
    adjacency_rows_mirror graph;

    sorted_adjacency_list_builder_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // run limit
    initial
    begin
        #8000000;
        $display("Verification failed");
        $finish;
    end

    // receiver stalls
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // note accepted requests and check output beats
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            graph.note_request(s_axis_tdata[1:0], s_axis_tdata[6:2], s_axis_tdata[11:7]);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            graph.check_beat({m_axis_tdata[1:0], m_axis_tuser, m_axis_tdata[6:2],
                              m_axis_tlast});
    end

    task automatic send_request(input logic [1:0] mode, input logic [4:0] src,
                                input logic [4:0] tgt);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, tgt, src, mode};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // wait for every pending beat, then let the block settle
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        // the last accepted request is noted by the end of this edge
        @(posedge clk);
        while (graph.pending_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_vertex_count(input logic [5:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        graph.vertex_count = value;
        cfg_valid <= 1'b0;
    endtask

    // mostly in-range inserts and lists, some clears, unused modes and wild vertices
    task automatic random_requests(input int count);
        int lim;
        int pick;
        logic [1:0] mode;
        logic [4:0] src;
        logic [4:0] tgt;
        for (int n = 0; n < count; n++)
        begin
            lim = graph.vertex_limit();
            pick = $urandom_range(99);
            if (pick < 60) mode = MODE_INSERT;
            else if (pick < 88) mode = MODE_LIST;
            else if (pick < 94) mode = MODE_CLEAR;
            else mode = MODE_UNUSED;
            if (lim > 0 && $urandom_range(9) != 0)
            begin
                src = 5'($urandom_range(lim - 1));
                tgt = 5'($urandom_range(lim - 1));
            end
            else
            begin
                src = 5'($urandom);
                tgt = 5'($urandom);
            end
            send_request(mode, src, tgt);
        end
    endtask

    initial
    begin
        graph = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        m_axis_tready = 1'b0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, duplicates, every mode, out of range
        send_request(MODE_LIST, 5'd0, 5'd0);
        send_request(MODE_INSERT, 5'd31, 5'd31);
        send_request(MODE_INSERT, 5'd31, 5'd0);
        send_request(MODE_INSERT, 5'd31, 5'd17);
        send_request(MODE_INSERT, 5'd31, 5'd17);
        send_request(MODE_INSERT, 5'd31, 5'd10);
        send_request(MODE_LIST, 5'd31, 5'd0);
        send_request(MODE_INSERT, 5'd0, 5'd0);
        send_request(MODE_LIST, 5'd0, 5'd31);
        send_request(MODE_UNUSED, 5'd31, 5'd31);
        send_request(MODE_CLEAR, 5'd21, 5'd10);
        send_request(MODE_LIST, 5'd31, 5'd0);
        send_request(MODE_INSERT, 5'd21, 5'd10);
        drain();
        write_vertex_count(6'd8);
        send_request(MODE_INSERT, 5'd8, 5'd1);
        send_request(MODE_INSERT, 5'd1, 5'd8);
        send_request(MODE_INSERT, 5'd7, 5'd7);
        send_request(MODE_LIST, 5'd8, 5'd0);
        send_request(MODE_LIST, 5'd7, 5'd0);
        drain();
        write_vertex_count(6'd0);
        send_request(MODE_INSERT, 5'd0, 5'd0);
        send_request(MODE_LIST, 5'd0, 5'd0);
        drain();

        // fill one row past its capacity
        write_vertex_count(6'd63);
        for (int k = 0; k < MAX_DEGREE + 1; k++)
            send_request(MODE_INSERT, 5'd5, 5'($urandom));
        send_request(MODE_LIST, 5'd5, 5'd0);
        drain();

        // random phases across settings and idling patterns
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
                default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
            endcase
            case (ph)
                0: write_vertex_count(6'd32);
                1: write_vertex_count(6'd1);
                2: write_vertex_count(6'd2);
                3: write_vertex_count(6'd63);
                4: write_vertex_count(6'd5);
                default: write_vertex_count(6'd32);
            endcase
            random_requests(13);
            drain();
        end

        if (graph.mismatches == 0 && graph.pending_beats.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
